### sv/itoad_pkg.sv
// Shared constants, job type and character helper for the integer-to-ASCII converter.
package itoad_pkg;

  localparam int unsigned MagW      = 32;
  localparam int unsigned DigitsMax = 10;
  localparam int unsigned IdxW      = 4;
  localparam int unsigned CharW     = 7;

  localparam logic [CharW-1:0] CharZero  = 7'h30;
  localparam logic [CharW-1:0] CharLowA  = 7'h61;
  localparam logic [CharW-1:0] CharMinus = 7'h2D;

  // floor(x / 10) == (x * RecipTen) >> RecipShift for every 32-bit x
  localparam logic [MagW-1:0] RecipTen   = 32'hCCCC_CCCD;
  localparam int unsigned     RecipShift = 35;

  typedef struct packed {
    logic [MagW-1:0] mag;
    logic            hex;
    logic            neg;
  } itoad_job_t;

  function automatic logic [CharW-1:0] digit_char(input logic [3:0] d);
    logic [CharW-1:0] c;
    if (d > 4'd9) begin
      c = CharLowA + CharW'(d) - CharW'(10);
    end else begin
      c = CharZero + CharW'(d);
    end
    return c;
  endfunction

endpackage

### sv/itoad_front.sv
// Input side: sign/magnitude classification and a two-word job queue.
module itoad_front
  import itoad_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [MagW-1:0] in_value_i,
  input  logic            in_hex_i,
  output logic            job_valid_o,
  input  logic            job_ready_i,
  output itoad_job_t      job_o
);

  itoad_job_t job_mem [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  itoad_job_t job_in;
  logic       push, pop;

  always_comb begin
    job_in.hex = in_hex_i;
    job_in.neg = ~in_hex_i & in_value_i[MagW-1];
    job_in.mag = job_in.neg ? (~in_value_i + MagW'(1)) : in_value_i;
  end

  assign in_ready_o  = (count_q != 2'd2);
  assign job_valid_o = (count_q != 2'd0);
  assign push        = in_valid_i & in_ready_o;
  assign pop         = job_valid_o & job_ready_i;
  assign job_o       = job_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      job_mem[wr_ptr_q] <= job_in;
    end
  end

endmodule

### sv/itoad_back.sv
// Output side: digit extraction into a small buffer, then character emission.
module itoad_back
  import itoad_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  output logic             job_ready_o,
  input  itoad_job_t       job_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [CharW-1:0] out_char_o,
  output logic             out_last_o
);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StConv = 3'b010,
    StEmit = 3'b100
  } itoad_state_e;

  itoad_state_e     state_q, state_d;
  logic [MagW-1:0]  mag_q, mag_d;
  logic             hex_q;
  logic             neg_q, neg_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [3:0]       dig_q [DigitsMax];
  logic             ovalid_q, ovalid_d;
  logic [CharW-1:0] ochar_q, ochar_d;
  logic             olast_q, olast_d;

  logic [2*MagW-1:0] prod;
  logic [MagW-1:0]   quot;
  logic [3:0]        ten_q_lo;
  logic [3:0]        rem;
  logic [MagW-1:0]   next_mag;
  logic [3:0]        digit;
  logic              conv_done;
  logic              take;
  logic              load;

  assign job_ready_o = (state_q == StIdle);
  assign take        = job_valid_i & job_ready_o;
  assign load        = (state_q == StEmit) & (~ovalid_q | out_ready_i);

  always_comb begin
    prod      = (2*MagW)'(mag_q) * (2*MagW)'(RecipTen);
    quot      = MagW'(prod >> RecipShift);
    ten_q_lo  = quot[3:0] * 4'd10;
    rem       = mag_q[3:0] - ten_q_lo;
    next_mag  = hex_q ? (mag_q >> 4) : quot;
    digit     = hex_q ? mag_q[3:0] : rem;
    conv_done = (next_mag == '0) || (idx_q == IdxW'(DigitsMax - 1));
  end

  always_comb begin
    state_d  = state_q;
    mag_d    = mag_q;
    neg_d    = neg_q;
    idx_d    = idx_q;
    ovalid_d = ovalid_q;
    ochar_d  = ochar_q;
    olast_d  = olast_q;
    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (take) begin
          mag_d   = job_i.mag;
          neg_d   = job_i.neg;
          idx_d   = '0;
          state_d = StConv;
        end
      end
      StConv: begin
        mag_d = next_mag;
        if (conv_done) begin
          state_d = StEmit;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      StEmit: begin
        if (load) begin
          ovalid_d = 1'b1;
          if (neg_q) begin
            ochar_d = CharMinus;
            olast_d = 1'b0;
            neg_d   = 1'b0;
          end else begin
            ochar_d = digit_char(dig_q[idx_q]);
            olast_d = (idx_q == '0);
            if (idx_q == '0) begin
              state_d = StIdle;
            end else begin
              idx_d = idx_q - IdxW'(1);
            end
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ovalid_q <= 1'b0;
      neg_q    <= 1'b0;
      idx_q    <= '0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      neg_q    <= neg_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    ochar_q <= ochar_d;
    olast_q <= olast_d;
    if (take) begin
      hex_q <= job_i.hex;
    end
    if (state_q == StConv) begin
      dig_q[idx_q] <= digit;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_char_o  = ochar_q;
  assign out_last_o  = olast_q;

endmodule

### sv/integer_to_ascii_digits_core.sv
// Top level of the 32-bit integer to ASCII decimal/hex converter.
// Each input word is one 32-bit value (tdata) with tuser selecting lower-case
// unsigned hex (1) or signed decimal (0); the block returns the characters most
// significant first, one per output word, tlast on the final one. A job with n
// digits and c characters (c = n, plus one for a leading '-') occupies the
// digit engine while it extracts the n digits through the divide-by-ten
// multiplier (or a 4-bit shift in hex), then hands the c characters one at a
// time to the output register, which stalls while tready is low. A two-word
// input queue accepts new words while the engine works or the output stalls,
// until it is full.
module integer_to_ascii_digits_core
  import itoad_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic        s_axis_tuser,   // [0] base_is_hex
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [6:0] char_code, [7] zero
  output logic        m_axis_tlast    // last_char
);

  itoad_job_t       job;
  logic             job_valid;
  logic             job_ready;
  logic [CharW-1:0] out_char;

  itoad_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_value_i (s_axis_tdata),
    .in_hex_i   (s_axis_tuser),
    .job_valid_o(job_valid),
    .job_ready_i(job_ready),
    .job_o      (job)
  );

  itoad_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(job_valid),
    .job_ready_o(job_ready),
    .job_i      (job),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_char_o (out_char),
    .out_last_o (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_char};

endmodule
